// ===== sv/permutation_enumerator_unit_assert.svh =====
// Assertion macros for the permutation enumerator
`ifndef PERMUTATION_ENUMERATOR_UNIT_ASSERT_SVH
`define PERMUTATION_ENUMERATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PEU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("peu: assertion failed");
`define PEU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("peu: assertion failed");
`else
`define PEU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PEU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/peu_pkg.sv =====
// Package: shared constants, types and controller encodings
`default_nettype none
package peu_pkg;
	localparam int NUM_SLOTS      = 6;
	localparam int MAX_ELEMS_DEF  = 6;
	localparam int VALUE_BITS_DEF = 8;
	localparam int POS_W          = $clog2(NUM_SLOTS);
	localparam int COUNT_W        = 3;
	localparam int NUM_REGS       = NUM_SLOTS + 1;
	localparam int REG_IDX_W      = $clog2(NUM_REGS);
	localparam int ADDR_W         = $clog2(NUM_REGS * 4);
	localparam int DATA_W         = 32;

	localparam logic [REG_IDX_W-1:0] REG_COUNT      = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ELEM_FIRST = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_ELEM_LAST  = REG_IDX_W'(NUM_SLOTS);

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_FIND,
		ST_SWAP,
		ST_REV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic restart;
		logic emit;
		logic find;
		logic swap;
		logic rev;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic exhausted;
		logic begun;
		logic piv_found;
		logic rev_more;
	} sts_t;
endpackage
`default_nettype wire

// ===== sv/peu_if.sv =====
// Interfaces: request and response channels
`default_nettype none
interface peu_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface peu_rsp_if #(
	parameter int VALUE_BITS = peu_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] slot_0;
	logic signed [VALUE_BITS-1:0] slot_1;
	logic signed [VALUE_BITS-1:0] slot_2;
	logic signed [VALUE_BITS-1:0] slot_3;
	logic signed [VALUE_BITS-1:0] slot_4;
	logic signed [VALUE_BITS-1:0] slot_5;
	logic                         is_final;
	logic                         ok;

	modport source (output valid, output slot_0, output slot_1, output slot_2,
		output slot_3, output slot_4, output slot_5, output is_final, output ok,
		input ready);
	modport sink (input valid, input slot_0, input slot_1, input slot_2,
		input slot_3, input slot_4, input slot_5, input is_final, input ok,
		output ready);
endinterface
`default_nettype wire

// ===== sv/peu_ctrl.sv =====
// Controller: sequences emit, pivot search, swap and suffix reversal
`default_nettype none
module peu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_restart,
	output logic               in_ready,
	input  wire logic          out_ready,
	output logic               out_valid,
	input  wire peu_pkg::sts_t sts,
	output peu_pkg::ctl_t      ctl
);
	import peu_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.restart = in_restart;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.start = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				ctl.emit = 1'b1;
				state_d  = sts.exhausted ? ST_DONE : ST_FIND;
			end
			ST_FIND: begin
				ctl.find = 1'b1;
				state_d  = sts.piv_found ? ST_SWAP : ST_DONE;
			end
			ST_SWAP: begin
				ctl.swap = 1'b1;
				state_d  = ST_REV;
			end
			ST_REV: begin
				ctl.rev = 1'b1;
				if (!sts.rev_more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== sv/peu_dp.sv =====
// Datapath: index array, pivot and swap search, result and output registers
`default_nettype none
module peu_dp #(
	parameter int MAX_ELEMS  = peu_pkg::MAX_ELEMS_DEF,
	parameter int VALUE_BITS = peu_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire peu_pkg::ctl_t                               ctl,
	input  wire logic                                        count_wr,
	input  wire logic [peu_pkg::COUNT_W-1:0]                 cfg_count,
	input  wire logic [peu_pkg::NUM_SLOTS-1:0][VALUE_BITS-1:0] elems,
	output peu_pkg::sts_t                                    sts,
	output logic [peu_pkg::NUM_SLOTS-1:0][VALUE_BITS-1:0]    slots,
	output logic                                             is_final,
	output logic                                             ok
);
	import peu_pkg::*;

	localparam int LIMIT = (MAX_ELEMS < NUM_SLOTS) ? MAX_ELEMS : NUM_SLOTS;

	pos_t idx_q [NUM_SLOTS];
	logic begun_q;
	logic exh_q;
	pos_t piv_q;
	pos_t lo_q;
	pos_t hi_q;
	logic [NUM_SLOTS-1:0][VALUE_BITS-1:0] res_slots_q;
	logic res_final_q;
	logic res_ok_q;
	logic [NUM_SLOTS-1:0][VALUE_BITS-1:0] slots_q;
	logic final_q;
	logic ok_q;

	pos_t n;
	pos_t piv_d;
	pos_t swp_d;
	logic piv_found;
	logic rev_more;

	always_comb begin
		if (cfg_count == '0) begin
			n = POS_W'(1);
		end else if (int'(cfg_count) > LIMIT) begin
			n = POS_W'(LIMIT);
		end else begin
			n = POS_W'(cfg_count);
		end
	end

	always_comb begin
		piv_found = 1'b0;
		piv_d     = '0;
		for (int k = 0; k < NUM_SLOTS - 1; k++) begin
			if (k + 1 < int'(n) && idx_q[k] < idx_q[k+1]) begin
				piv_found = 1'b1;
				piv_d     = POS_W'(k);
			end
		end
	end

	always_comb begin
		swp_d = piv_q;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (k > int'(piv_q) && k < int'(n) && idx_q[k] > idx_q[piv_q]) begin
				swp_d = POS_W'(k);
			end
		end
	end

	assign rev_more = lo_q < hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				idx_q[k] <= POS_W'(k);
			end
			begun_q <= 1'b0;
			exh_q   <= 1'b0;
		end else if (count_wr) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				idx_q[k] <= POS_W'(k);
			end
			begun_q <= 1'b0;
			exh_q   <= 1'b0;
		end else if (ctl.start && (ctl.restart || !begun_q)) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				idx_q[k] <= POS_W'(k);
			end
			begun_q <= 1'b1;
			exh_q   <= 1'b0;
		end else if (ctl.find && !piv_found) begin
			exh_q <= 1'b1;
		end else if (ctl.swap) begin
			idx_q[piv_q] <= idx_q[swp_d];
			idx_q[swp_d] <= idx_q[piv_q];
		end else if (ctl.rev && rev_more) begin
			idx_q[lo_q] <= idx_q[hi_q];
			idx_q[hi_q] <= idx_q[lo_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.find) begin
			piv_q <= piv_d;
		end
		if (ctl.swap) begin
			lo_q <= piv_q + POS_W'(1);
			hi_q <= n - POS_W'(1);
		end else if (ctl.rev && rev_more) begin
			lo_q <= lo_q + POS_W'(1);
			hi_q <= hi_q - POS_W'(1);
		end
		if (ctl.emit) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				res_slots_q[k] <= (k < int'(n) && !exh_q) ? elems[idx_q[k]] : '0;
			end
			res_ok_q    <= !exh_q;
			res_final_q <= 1'b0;
		end else if (ctl.find && !piv_found) begin
			res_final_q <= 1'b1;
		end
		if (ctl.load_out) begin
			slots_q <= res_slots_q;
			final_q <= res_final_q;
			ok_q    <= res_ok_q;
		end
	end

	assign sts.exhausted = exh_q;
	assign sts.begun     = begun_q;
	assign sts.piv_found = piv_found;
	assign sts.rev_more  = rev_more;
	assign slots         = slots_q;
	assign is_final      = final_q;
	assign ok            = ok_q;
endmodule
`default_nettype wire

// ===== sv/permutation_enumerator_unit.sv =====
// Top level: permutation enumerator with APB register port
// Each request emits the current ordering; unless exhausted, a pivot search follows, and on
// all but the last ordering one swap, then one reversal swap per cycle.
// A new request is taken while the previous response beat still waits in the output
// register.
// Reset: asynchronous, clears index array to identity, count to one, values to zero.
`default_nettype none
`include "permutation_enumerator_unit_assert.svh"
module permutation_enumerator_unit #(
	parameter int MAX_ELEMS  = peu_pkg::MAX_ELEMS_DEF,
	parameter int VALUE_BITS = peu_pkg::VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [peu_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [peu_pkg::DATA_W-1:0]   pwdata,
	output logic      [peu_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	peu_req_if.sink                           req,
	peu_rsp_if.source                         rsp
);
	import peu_pkg::*;

	logic [COUNT_W-1:0]                   count_q;
	logic [NUM_SLOTS-1:0][VALUE_BITS-1:0] elem_q;
	logic [REG_IDX_W-1:0]                 reg_idx;
	logic                                 wr_beat;
	logic                                 count_wr;
	logic                                 elem_sel;
	pos_t                                 elem_idx;
	ctl_t                                 ctl;
	sts_t                                 sts;
	logic [NUM_SLOTS-1:0][VALUE_BITS-1:0] slots;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[ADDR_W-1:2];
	assign wr_beat  = psel && penable && pwrite;
	assign count_wr = wr_beat && (reg_idx == REG_COUNT);
	assign elem_sel = (reg_idx >= REG_ELEM_FIRST) && (reg_idx <= REG_ELEM_LAST);
	assign elem_idx = POS_W'(reg_idx - REG_ELEM_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
			elem_q  <= '0;
		end else if (wr_beat) begin
			if (reg_idx == REG_COUNT) begin
				count_q <= pwdata[COUNT_W-1:0];
			end else if (elem_sel) begin
				elem_q[elem_idx] <= pwdata[VALUE_BITS-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_COUNT) begin
			prdata = DATA_W'(count_q);
		end else if (elem_sel) begin
			prdata = DATA_W'(elem_q[elem_idx]);
		end
	end

	peu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_restart (req.restart),
		.in_ready   (req.ready),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.sts        (sts),
		.ctl        (ctl)
	);

	peu_dp #(
		.MAX_ELEMS  (MAX_ELEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.count_wr  (count_wr),
		.cfg_count (count_q),
		.elems     (elem_q),
		.sts       (sts),
		.slots     (slots),
		.is_final  (rsp.is_final),
		.ok        (rsp.ok)
	);

	assign rsp.slot_0 = slots[0];
	assign rsp.slot_1 = slots[1];
	assign rsp.slot_2 = slots[2];
	assign rsp.slot_3 = slots[3];
	assign rsp.slot_4 = slots[4];
	assign rsp.slot_5 = slots[5];

	`PEU_ASSERT_IMP(a_exhausted_not_final, clk, arst_n, rsp.valid && !rsp.ok, !rsp.is_final)
	`PEU_ASSERT_NXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, !req.ready)
	`PEU_ASSERT_NXT(a_count_wr_clears, clk, arst_n, count_wr, !sts.begun && !sts.exhausted)
endmodule
`default_nettype wire

// ===== tb/perm_order_checker.sv =====
// Checker: predicts each ordering from request and register beats and compares the replies
module perm_order_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [peu_pkg::ADDR_W-1:0]     paddr,
	input  logic [peu_pkg::DATA_W-1:0]     pwdata,
	peu_req_if                             req_mon,
	peu_rsp_if                             rsp_mon,
	output int                             mismatches,
	output int                             pending,
	output int                             checked,
	output int                             finals,
	output int                             empties
);
	timeunit 1ns;
	timeprecision 1ps;
	import peu_pkg::*;

	localparam int VB        = VALUE_BITS_DEF;
	localparam int POS_DEPTH = 8;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][VB-1:0] slot;
		logic                         is_final;
		logic                         ok;
	} ordering_t;

	logic [COUNT_W-1:0] count_reg;
	logic [VB-1:0]      value_reg [NUM_SLOTS];
	logic [2:0]         perm_pos [POS_DEPTH];
	logic               run_out;
	logic               started;
	ordering_t          orderings_due [$];
	int                 fail_total;
	int                 reply_total;
	int                 final_total;
	int                 empty_total;

	function automatic void reset_positions();
		for (int k = 0; k < POS_DEPTH; k++)
			perm_pos[k] = 3'(k);
	endfunction

	function automatic ordering_t next_ordering(input logic restart_bit);
		ordering_t  o;
		int         n;
		int         i;
		int         j;
		int         lo;
		int         hi;
		logic [2:0] t;
		logic [2:0] p;
		bit         more;
		o = '0;
		more = 1'b0;
		n = int'(count_reg);
		if (n < 1)
			n = 1;
		if (n > MAX_ELEMS_DEF)
			n = MAX_ELEMS_DEF;
		if (restart_bit || !started) begin
			reset_positions();
			run_out = 1'b0;
			started = 1'b1;
		end
		if (run_out)
			return o;
		for (int k = 0; k < n; k++) begin
			p = perm_pos[k];
			o.slot[k] = (p < NUM_SLOTS) ? value_reg[p] : '0;
		end
		if (n >= 2) begin
			i = n - 1;
			while (i > 0 && perm_pos[i-1] > perm_pos[i])
				i--;
			if (i > 0) begin
				i--;
				j = n - 1;
				while (perm_pos[j] < perm_pos[i])
					j--;
				t = perm_pos[i];
				perm_pos[i] = perm_pos[j];
				perm_pos[j] = t;
				lo = i + 1;
				hi = n - 1;
				while (lo < hi) begin
					t = perm_pos[lo];
					perm_pos[lo] = perm_pos[hi];
					perm_pos[hi] = t;
					lo++;
					hi--;
				end
				more = 1'b1;
			end
		end
		if (!more)
			run_out = 1'b1;
		o.is_final = !more;
		o.ok = 1'b1;
		return o;
	endfunction

	function automatic void note_mismatch(input string what);
		fail_total++;
		if (fail_total <= MAX_SHOWN)
			$display("%0t: mismatch: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ordering_t                want;
		ordering_t                got;
		logic [REG_IDX_W-1:0]     reg_idx;
		if (!arst_n) begin
			count_reg = COUNT_W'(1);
			for (int k = 0; k < NUM_SLOTS; k++)
				value_reg[k] = '0;
			reset_positions();
			run_out = 1'b0;
			started = 1'b0;
			orderings_due.delete();
			fail_total = 0;
			reply_total = 0;
			final_total = 0;
			empty_total = 0;
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
			finals <= 0;
			empties <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				reg_idx = paddr[ADDR_W-1:2];
				if (reg_idx == REG_COUNT) begin
					count_reg = pwdata[COUNT_W-1:0];
					reset_positions();
					run_out = 1'b0;
					started = 1'b0;
				end else if (reg_idx >= REG_ELEM_FIRST && reg_idx <= REG_ELEM_LAST) begin
					value_reg[reg_idx - REG_ELEM_FIRST] = pwdata[VB-1:0];
				end
			end
			if (rsp_mon.valid && rsp_mon.ready) begin
				got.slot = {rsp_mon.slot_5, rsp_mon.slot_4, rsp_mon.slot_3,
					rsp_mon.slot_2, rsp_mon.slot_1, rsp_mon.slot_0};
				got.is_final = rsp_mon.is_final;
				got.ok = rsp_mon.ok;
				if (orderings_due.size() == 0) begin
					note_mismatch($sformatf("reply beat with nothing outstanding (ok %b)", got.ok));
				end else begin
					want = orderings_due.pop_front();
					reply_total++;
					if (want.is_final)
						final_total++;
					if (!want.ok)
						empty_total++;
					for (int k = 0; k < NUM_SLOTS; k++)
						if (got.slot[k] !== want.slot[k])
							note_mismatch($sformatf("slot_%0d expected %0d, got %0d", k,
								$signed(want.slot[k]), $signed(got.slot[k])));
					if (got.is_final !== want.is_final)
						note_mismatch($sformatf("is_final expected %b, got %b",
							want.is_final, got.is_final));
					if (got.ok !== want.ok)
						note_mismatch($sformatf("ok expected %b, got %b", want.ok, got.ok));
				end
			end
			if (req_mon.valid && req_mon.ready)
				orderings_due.insert(orderings_due.size(), next_ordering(req_mon.restart));
			mismatches <= fail_total;
			pending <= orderings_due.size();
			checked <= reply_total;
			finals <= final_total;
			empties <= empty_total;
		end
	end
endmodule

// ===== tb/tb_permutation_enumerator_unit.sv =====
// Testbench top: drives requests and register writes, stalls replies, gives the verdict
module tb_permutation_enumerator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import peu_pkg::*;

	localparam int TOTAL_ITEMS   = 850;
	localparam int STAGE_ONE_END = 283;
	localparam int STAGE_TWO_END = 566;
	localparam int HOLD_AT       = 700;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RESET_CYCLES  = 6;
	localparam logic [REG_IDX_W-1:0] REG_NONE = REG_IDX_W'(NUM_REGS);

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	peu_req_if req_if ();
	peu_rsp_if rsp_if ();

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int phases;
	int quiet_cycles;
	int live_n;
	bit stall_rsp;
	int mismatches;
	int pending;
	int checked;
	int finals;
	int empties;

	permutation_enumerator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	perm_order_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.req_mon    (req_if),
		.rsp_mon    (rsp_if),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.finals     (finals),
		.empties    (empties)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d replies outstanding",
				quiet_cycles, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// hold ready low for a long stretch on request, else random stalls
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_rsp) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_rsp = 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_request(input logic restart_bit);
		int gap;
		if (items_sent < STAGE_ONE_END) begin
			send_idle_pct = 16;
			recv_idle_pct = 79;
		end else if (items_sent < STAGE_TWO_END) begin
			send_idle_pct = 79;
			recv_idle_pct = 16;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.restart <= restart_bit;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] c, input logic [DATA_W-1:0] upper);
		reg_write(REG_COUNT, (upper & ~DATA_W'(7)) | DATA_W'(c));
		live_n = (c == 0) ? 1 : ((int'(c) > MAX_ELEMS_DEF) ? MAX_ELEMS_DEF : int'(c));
	endtask

	task automatic random_config();
		int pick;
		logic [COUNT_W-1:0] c;
		if ($urandom_range(99) < 70) begin
			pick = $urandom_range(99);
			if (pick < 5)
				c = 3'd0;
			else if (pick < 10)
				c = 3'd7;
			else if (pick < 20)
				c = 3'd1;
			else if (pick < 35)
				c = 3'd2;
			else if (pick < 60)
				c = 3'd3;
			else if (pick < 80)
				c = 3'd4;
			else if (pick < 93)
				c = 3'd5;
			else
				c = 3'd6;
			set_count(c, ($urandom_range(3) == 0) ? DATA_W'($urandom) : '0);
		end
		for (int i = 0; i < NUM_SLOTS; i++)
			if ($urandom_range(99) < 60)
				reg_write(REG_ELEM_FIRST + REG_IDX_W'(i),
					($urandom_range(3) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(255)));
		if ($urandom_range(99) < 5)
			reg_write(REG_NONE, DATA_W'($urandom));
	endtask

	initial begin
		logic [7:0] edge_vals [NUM_SLOTS];
		int         full;
		int         len;
		bit         stall_done;
		bit         walk_all;
		edge_vals = '{8'h80, 8'h7F, 8'h01, 8'h55, 8'hAA, 8'hFF};
		stall_done = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.restart <= 1'b0;
		live_n = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first request without a restart, then past the end, then restart
		push_request(1'b0);
		push_request(1'b0);
		push_request(1'b1);
		wait_drained();

		set_count(3'd3, '0);
		for (int i = 0; i < NUM_SLOTS; i++)
			reg_write(REG_ELEM_FIRST + REG_IDX_W'(i), DATA_W'(edge_vals[i]));
		repeat (7) push_request(1'b0);
		push_request(1'b1);
		push_request(1'b0);
		wait_drained();

		// value rewritten mid-walk, position kept
		reg_write(REG_ELEM_FIRST + REG_IDX_W'(1), DATA_W'(8'h81));
		push_request(1'b0);
		push_request(1'b0);
		wait_drained();

		reg_write(REG_NONE, '1);
		push_request(1'b0);
		wait_drained();

		set_count(3'd0, '0);
		push_request(1'b0);
		push_request(1'b0);
		wait_drained();

		set_count(3'd7, '1);
		push_request(1'b1);
		push_request(1'b0);
		push_request(1'b0);
		wait_drained();

		set_count(3'd2, '0);
		repeat (3) push_request(1'b0);

		while (items_sent < TOTAL_ITEMS) begin
			wait_drained();
			random_config();
			phases++;
			full = 1;
			for (int k = 2; k <= live_n; k++)
				full *= k;
			walk_all = (live_n <= 5) && ($urandom_range(99) < 60);
			len = walk_all ? full + $urandom_range(0, 3) : $urandom_range(3, 30);
			for (int k = 0; k < len; k++) begin
				if (!stall_done && items_sent >= HOLD_AT) begin
					stall_rsp = 1'b1;
					stall_done = 1'b1;
				end
				if (k == 0 && walk_all)
					push_request(1'b1);
				else
					push_request($urandom_range(99) < 3);
			end
		end
		wait_drained();

		$display("Sent %0d requests over %0d register settings; %0d replies checked.",
			items_sent, phases, checked);
		$display("%0d walks reached their last ordering; %0d replies came after the end.",
			finals, empties);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
